// File: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the rational arithmetic block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is held.
`define RARC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that is skipped while reset is held and while $past(!rstn) still holds.
`define RARC_ASSERT_POST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) $past(!rstn) || !rstn || (prop)) else $error(msg);

`endif

// File: rtl/core/rarc_pkg.sv
// Shared constants of the rational arithmetic block: codes, widths, the reset cap and the wide type.
package rarc_pkg;

    localparam int NUM_W  = 64;
    localparam int DEN_W  = 63;
    localparam int WIDE_W = 128;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_WIDE = 2'd2;
    localparam logic [1:0] ST_CAP  = 2'd3;

    localparam logic [DEN_W-1:0] CAP_RESET = 63'd1000000000;

    typedef logic [WIDE_W-1:0] wide_t;

endpackage

// File: rtl/core/rational_alu_reduce_cap.sv
// Exact rational ALU: cross products, gcd reduction and division on one shared adder, then status.
//
// Usage: a request on the s_ channel carries the operation in s_tuser and two
// fractions in s_tdata. The block replies with one result on the m_ channel:
// the status in m_tuser and the reduced fraction in m_tdata. cfg_we with
// cfg_wdata writes the cap on the absolute numerator and on the denominator.
// Sequencing: the arithmetic runs through one 129-bit add/subtract unit under a small
// sequencer. Each 64-bit product is formed by shift and add (two or three per request),
// the binary gcd steps through its shifts and subtracts one at a time, and each of
// the two quotient divisions restores its quotient bit by bit. A division by a zero
// divisor presents its result the cycle after the request is taken.
// Throughput: one request at a time; s_tready is high only while idle.
// Reset: synchronous, active low; the block comes up idle, the cap returns to
// one billion, and no result is pending.
// Stall: a finished result is held stable in the output register with
// m_tvalid high until m_tready is seen; no new request is taken meanwhile.
module rational_alu_reduce_cap (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rarc_pkg::DEN_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata fields from bit 0: a_num[63:0], a_den[62:0], b_num[63:0], b_den[62:0], pad
    input  logic [255:0]                s_tdata,
    // s_tuser fields from bit 0: op[1:0]
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata fields from bit 0: res_num[63:0], res_den[62:0], pad
    output logic [127:0]                m_tdata,
    // m_tuser fields from bit 0: status[1:0]
    output logic [1:0]                  m_tuser
);
    import rarc_pkg::*;
    `include "assert_macros.svh"

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL_LD = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_SADD   = 4'd3;
    localparam logic [3:0] S_CHK    = 4'd4;
    localparam logic [3:0] S_G_TWO  = 4'd5;
    localparam logic [3:0] S_G_AODD = 4'd6;
    localparam logic [3:0] S_G_BEV  = 4'd7;
    localparam logic [3:0] S_G_CMP  = 4'd8;
    localparam logic [3:0] S_G_SHL  = 4'd9;
    localparam logic [3:0] S_DIV_N  = 4'd10;
    localparam logic [3:0] S_DIV_D  = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    // Product slots: which cross product is being formed and where it lands.
    localparam logic [1:0] PI_N = 2'd0;
    localparam logic [1:0] PI_R = 2'd1;
    localparam logic [1:0] PI_D = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [DEN_W-1:0]  cap_reg;
    logic [1:0]        op_reg, pi_reg;
    logic [NUM_W-1:0]  am_reg, bm_reg, mp_reg;
    logic [DEN_W-1:0]  ad_reg, bd_reg;
    logic              sa_reg, sb_reg, neg_reg;
    wide_t             nm_reg, dm_reg, r_reg, ga_reg, gb_reg;
    logic [6:0]        cnt_reg, k_reg;
    logic [1:0]        status_reg;
    logic [NUM_W-1:0]  onum_reg;
    logic [DEN_W-1:0]  oden_reg;

    logic [NUM_W-1:0]  in_an, in_bn, in_am, in_bm;
    logic [NUM_W-1:0]  mx, my;
    logic [128:0]      opa, opb;
    logic              sub;
    logic [129:0]      sum;
    logic              carry;
    logic              div_bit;
    logic              n_wide;
    logic [NUM_W-1:0]  num_mag;

    assign in_an = s_tdata[63:0];
    assign in_bn = s_tdata[190:127];
    assign in_am = in_an[63] ? (~in_an + 64'd1) : in_an;
    assign in_bm = in_bn[63] ? (~in_bn + 64'd1) : in_bn;

    // Operands of the cross product in the current slot.
    always_comb begin
        case (pi_reg)
            PI_N: begin
                mx = am_reg;
                my = (op_reg == OP_MUL) ? bm_reg : {1'b0, bd_reg};
            end
            PI_R: begin
                mx = bm_reg;
                my = {1'b0, ad_reg};
            end
            default: begin
                mx = {1'b0, ad_reg};
                my = (op_reg == OP_DIV) ? bm_reg : {1'b0, bd_reg};
            end
        endcase
    end

    assign div_bit = (state_reg == S_DIV_N) ? nm_reg[127] : dm_reg[127];

    // The shared add/subtract unit and its operand selection.
    always_comb begin
        opa = '0;
        opb = '0;
        sub = 1'b0;
        case (state_reg)
            S_MUL: begin
                case (pi_reg)
                    PI_N:    opa = {1'b0, nm_reg};
                    PI_R:    opa = {1'b0, r_reg};
                    default: opa = {1'b0, dm_reg};
                endcase
                opb = {1'b0, gb_reg};
            end
            S_SADD: begin
                opa = {1'b0, nm_reg};
                opb = {1'b0, r_reg};
                sub = sa_reg != sb_reg;
            end
            S_G_CMP: begin
                opa = {1'b0, gb_reg};
                opb = {1'b0, ga_reg};
                sub = 1'b1;
            end
            S_DIV_N, S_DIV_D: begin
                opa = {r_reg, div_bit};
                opb = {1'b0, ga_reg};
                sub = 1'b1;
            end
            default: begin
                opa = '0;
            end
        endcase
    end

    assign sum   = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {129'd0, sub};
    assign carry = sum[129];

    // Range check of the reduced fraction.
    assign n_wide = (nm_reg[127:64] != '0) || (dm_reg[127:63] != '0) ||
                    (neg_reg ? (nm_reg[63:0] > 64'h8000_0000_0000_0000)
                             : nm_reg[63]);
    assign num_mag = nm_reg[63:0];

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == OP_DIV && in_bm == '0) state_next = S_OUT;
                    else                                  state_next = S_MUL_LD;
                end
            end
            S_MUL_LD: state_next = S_MUL;
            S_MUL: begin
                if (cnt_reg[5:0] == 6'd63) begin
                    if (pi_reg == PI_D) begin
                        state_next = (op_reg inside {OP_ADD, OP_SUB}) ? S_SADD : S_CHK;
                    end else begin
                        state_next = S_MUL_LD;
                    end
                end
            end
            S_SADD: begin
                if (sa_reg == sb_reg || carry) state_next = S_CHK;
            end
            S_CHK: begin
                if (dm_reg == '0 || nm_reg == '0) state_next = S_OUT;
                else                              state_next = S_G_TWO;
            end
            S_G_TWO: begin
                if (ga_reg[0] || gb_reg[0]) state_next = S_G_AODD;
            end
            S_G_AODD: begin
                if (ga_reg[0]) state_next = S_G_BEV;
            end
            S_G_BEV: begin
                if (gb_reg == '0)   state_next = S_G_SHL;
                else if (gb_reg[0]) state_next = S_G_CMP;
            end
            S_G_CMP: begin
                if (carry) state_next = S_G_BEV;
            end
            S_G_SHL: begin
                if (k_reg == '0) state_next = S_DIV_N;
            end
            S_DIV_N: begin
                if (cnt_reg == 7'd127) state_next = S_DIV_D;
            end
            S_DIV_D: begin
                if (cnt_reg == 7'd127) state_next = S_FIN;
            end
            S_FIN: state_next = S_OUT;
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state and the cap register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cap_reg   <= CAP_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) cap_reg <= cfg_wdata;
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                op_reg     <= s_tuser;
                am_reg     <= in_am;
                bm_reg     <= in_bm;
                ad_reg     <= s_tdata[126:64];
                bd_reg     <= s_tdata[253:191];
                sa_reg     <= in_an[63];
                sb_reg     <= (s_tuser == OP_SUB) ? !in_bn[63] : in_bn[63];
                neg_reg    <= in_an[63] ^ in_bn[63];
                pi_reg     <= PI_N;
                status_reg <= ST_DIV0;
                onum_reg   <= '0;
                oden_reg   <= {{(DEN_W-1){1'b0}}, 1'b1};
            end
            S_MUL_LD: begin
                gb_reg  <= {64'd0, mx};
                mp_reg  <= my;
                cnt_reg <= '0;
                case (pi_reg)
                    PI_N:    nm_reg <= '0;
                    PI_R:    r_reg  <= '0;
                    default: dm_reg <= '0;
                endcase
            end
            S_MUL: begin
                if (mp_reg[0]) begin
                    case (pi_reg)
                        PI_N:    nm_reg <= sum[127:0];
                        PI_R:    r_reg  <= sum[127:0];
                        default: dm_reg <= sum[127:0];
                    endcase
                end
                gb_reg  <= {gb_reg[126:0], 1'b0};
                mp_reg  <= {1'b0, mp_reg[63:1]};
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg[5:0] == 6'd63) begin
                    if (pi_reg == PI_N && (op_reg inside {OP_ADD, OP_SUB})) begin
                        pi_reg <= PI_R;
                    end else begin
                        pi_reg <= PI_D;
                    end
                end
            end
            S_SADD: begin
                // Same signs add; otherwise larger minus smaller, swapping once.
                if (sa_reg == sb_reg || carry) begin
                    nm_reg  <= sum[127:0];
                    neg_reg <= sa_reg;
                end else begin
                    nm_reg <= r_reg;
                    r_reg  <= nm_reg;
                    sa_reg <= sb_reg;
                    sb_reg <= sa_reg;
                end
            end
            S_CHK: begin
                ga_reg <= nm_reg;
                gb_reg <= dm_reg;
                k_reg  <= '0;
                if (dm_reg == '0) begin
                    status_reg <= ST_DIV0;
                end else if (nm_reg == '0) begin
                    status_reg <= ST_OK;
                end
            end
            S_G_TWO: begin
                if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_reg <= {1'b0, ga_reg[127:1]};
                    gb_reg <= {1'b0, gb_reg[127:1]};
                    k_reg  <= k_reg + 7'd1;
                end
            end
            S_G_AODD: begin
                if (!ga_reg[0]) ga_reg <= {1'b0, ga_reg[127:1]};
            end
            S_G_BEV: begin
                if (gb_reg != '0 && !gb_reg[0]) gb_reg <= {1'b0, gb_reg[127:1]};
            end
            S_G_CMP: begin
                if (carry) begin
                    gb_reg <= sum[127:0];
                end else begin
                    ga_reg <= gb_reg;
                    gb_reg <= ga_reg;
                end
            end
            S_G_SHL: begin
                r_reg   <= '0;
                cnt_reg <= '0;
                if (k_reg != '0) begin
                    ga_reg <= {ga_reg[126:0], 1'b0};
                    k_reg  <= k_reg - 7'd1;
                end
            end
            S_DIV_N, S_DIV_D: begin
                // Restoring division, one quotient bit a cycle into the dividend.
                // The remainder starts from zero again for the second division.
                r_reg   <= (state_reg == S_DIV_N && cnt_reg == 7'd127) ? '0 :
                           (carry ? sum[127:0] : {r_reg[126:0], div_bit});
                cnt_reg <= cnt_reg + 7'd1;
                if (state_reg == S_DIV_N) begin
                    nm_reg <= {nm_reg[126:0], carry};
                end else begin
                    dm_reg <= {dm_reg[126:0], carry};
                end
            end
            S_FIN: begin
                if (n_wide) begin
                    status_reg <= ST_WIDE;
                end else begin
                    onum_reg   <= neg_reg ? (~num_mag + 64'd1) : num_mag;
                    oden_reg   <= dm_reg[62:0];
                    status_reg <= (num_mag > {1'b0, cap_reg} || dm_reg[62:0] > cap_reg)
                                  ? ST_CAP : ST_OK;
                end
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = state_reg == S_OUT;
    assign m_tdata  = {1'b0, oden_reg, onum_reg};
    assign m_tuser  = status_reg;

    `RARC_ASSERT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "request accepted while busy")
    `RARC_ASSERT(a_one_side, aclk, aresetn, !(s_tready && m_tvalid), "ready while a result is pending")
    `RARC_ASSERT(a_den_nonzero, aclk, aresetn, m_tvalid && (m_tuser == ST_OK) |-> m_tdata[126:64] != '0, "zero denominator on success")
    `RARC_ASSERT_POST(a_fail_zero, aclk, aresetn, !(m_tvalid && (m_tuser == ST_DIV0 || m_tuser == ST_WIDE)) || (m_tdata[63:0] == '0 && m_tdata[126:64] == 63'd1), "failed result not zero over one")

endmodule

// File: dv/rational_alu_reduce_cap_tb.sv
// Testbench for the rational ALU: stream stimulus, scoreboard and result checks.
`timescale 1ns / 1ps

module rational_alu_reduce_cap_tb;
    import rarc_pkg::*;

    localparam logic [63:0] NUM_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] NUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] DEN_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]        status;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } fraction_t;

    // Scoreboard: predicts each reduced fraction and checks results in order.
    class fraction_board;
        fraction_t  pending[$];
        logic [62:0] cap;
        int         mismatches;

        function new();
            cap = CAP_RESET;
            mismatches = 0;
        endfunction

        // Exact prediction on wide signed integers.
        function fraction_t reduce(logic [1:0] op, logic [63:0] an, logic [62:0] ad,
                                   logic [63:0] bn, logic [62:0] bd);
            fraction_t r;
            logic signed [131:0] n, d;
            logic [131:0] nmag, dmag, x, y, t;
            logic neg;
            r.status = ST_DIV0;
            r.num = '0;
            r.den = 63'd1;
            case (op)
                OP_ADD: begin
                    n = $signed(an) * $signed({1'b0, bd}) + $signed(bn) * $signed({1'b0, ad});
                    d = $signed({1'b0, ad}) * $signed({1'b0, bd});
                end
                OP_SUB: begin
                    n = $signed(an) * $signed({1'b0, bd}) - $signed(bn) * $signed({1'b0, ad});
                    d = $signed({1'b0, ad}) * $signed({1'b0, bd});
                end
                OP_MUL: begin
                    n = $signed(an) * $signed(bn);
                    d = $signed({1'b0, ad}) * $signed({1'b0, bd});
                end
                default: begin
                    n = $signed(an) * $signed({1'b0, bd});
                    d = $signed({1'b0, ad}) * $signed(bn);
                end
            endcase
            if (d == 0) return r;
            if (n == 0) begin
                r.status = ST_OK;
                return r;
            end
            neg = (n < 0) != (d < 0);
            nmag = (n < 0) ? -n : n;
            dmag = (d < 0) ? -d : d;
            // Euclid on the magnitudes
            x = nmag;
            y = dmag;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            nmag = nmag / x;
            dmag = dmag / x;
            if (dmag > DEN_MAX || nmag > (neg ? {68'd0, NUM_MIN} : {68'd0, NUM_MAX})) begin
                r.status = ST_WIDE;
                return r;
            end
            r.num = neg ? -nmag[63:0] : nmag[63:0];
            r.den = dmag[62:0];
            r.status = (nmag > cap || dmag > cap) ? ST_CAP : ST_OK;
            return r;
        endfunction

        function void note_request(logic [1:0] op, logic [63:0] an, logic [62:0] ad,
                                   logic [63:0] bn, logic [62:0] bd);
            pending.insert(pending.size(), reduce(op, an, ad, bn, bd));
        endfunction

        function void check_result(logic [1:0] status, logic [63:0] num, logic [62:0] den);
            fraction_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d num %0d den %0d",
                             status, $signed(num), den);
                return;
            end
            e = pending.pop_front();
            if (e.status !== status || e.num !== num || e.den !== den) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d %0d/%0d, got %0d %0d/%0d",
                             e.status, $signed(e.num), e.den, status, $signed(num), den);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [62:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [255:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [127:0] m_tdata;
    logic [1:0]  m_tuser;

    fraction_board board;
    bit          long_hold;
    bit          hold_active;

    rational_alu_reduce_cap dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Generous limit, several times the slowest requests plus the stalls.
    initial begin
        #60_000_000;
        $display("rational_alu_reduce_cap_tb: done, errors");
        $finish;
    end

    // Results are checked at the edge where they are accepted.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata[63:0], m_tdata[126:64]);
    end

    // Receiver: stretches of steady, random and sparse readiness, plus one long hold.
    initial begin
        int mode;
        int len;
        m_tready = 1'b0;
        hold_active = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                hold_active = 1'b1;
                m_tready = 1'b0;
                repeat (3000) @(negedge aclk);
                hold_active = 1'b0;
            end
            mode = $urandom_range(0, 2);
            len = $urandom_range(1, 600);
            repeat (len) begin
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(0, 1));
                    default: m_tready = ($urandom_range(0, 9) == 0);
                endcase
                @(negedge aclk);
            end
        end
    end

    task automatic write_cap(logic [62:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        board.cap = value;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    // One request; valid stays high into the next request unless a gap is asked for.
    task automatic send(logic [1:0] op, logic [63:0] an, logic [62:0] ad,
                        logic [63:0] bn, logic [62:0] bd, int gap);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {2'b00, bd, bn, ad, an};
        do @(posedge aclk); while (!s_tready);
        board.note_request(op, an, ad, bn, bd);
        @(negedge aclk);
    endtask

    function automatic logic [63:0] pick_num();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return NUM_MIN;
            2: return NUM_MAX;
            3: return {{32{1'b0}}, $urandom()};
            4: return {$urandom(), $urandom()};
            5: return -64'($urandom_range(0, 1_000_000));
            default: return 64'($signed($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    function automatic logic [62:0] pick_den();
        logic [62:0] d;
        case ($urandom_range(0, 6))
            0: d = DEN_MAX;
            1: d = 63'({$urandom(), $urandom()});
            2: d = {31'd0, $urandom()};
            3: d = 63'($urandom_range(1, 1_000_000));
            default: d = 63'($urandom_range(1, 24));
        endcase
        return (d == 0) ? 63'd1 : d;
    endfunction

    task automatic random_phase(int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            send(2'($urandom_range(0, 3)), pick_num(), pick_den(), pick_num(), pick_den(),
                 ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 700));
            sent++;
            for (int i = 1; i < burst && sent < count; i++) begin
                send(2'($urandom_range(0, 3)), pick_num(), pick_den(), pick_num(),
                     pick_den(), 0);
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        logic [62:0] caps[5];
        board = new();
        long_hold = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_ADD;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, each operation and each status case at the reset cap.
        send(OP_ADD, 64'd1, 63'd2, 64'd1, 63'd3, 0);
        send(OP_SUB, 64'd1, 63'd2, 64'd1, 63'd2, 0);
        send(OP_MUL, -64'd3, 63'd4, 64'd8, 63'd9, 0);
        send(OP_DIV, 64'd5, 63'd7, -64'd10, 63'd21, 0);
        send(OP_DIV, 64'd5, 63'd7, 64'd0, 63'd3, 0);
        send(OP_DIV, 64'd0, 63'd7, 64'd0, 63'd3, 2);
        send(OP_MUL, 64'd0, 63'd7, NUM_MIN, DEN_MAX, 0);
        send(OP_MUL, NUM_MAX, 63'd1, NUM_MAX, 63'd1, 0);
        send(OP_ADD, NUM_MAX, 63'd1, NUM_MAX, 63'd1, 0);
        send(OP_SUB, NUM_MIN, 63'd1, 64'd1, 63'd1, 0);
        send(OP_MUL, NUM_MIN, 63'd1, 64'd1, 63'd1, 0);
        send(OP_DIV, NUM_MIN, 63'd1, -64'd1, 63'd1, 0);
        send(OP_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX, 5);
        send(OP_DIV, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX, 0);
        send(OP_MUL, 64'd1, DEN_MAX, 64'd1, DEN_MAX, 0);
        send(OP_ADD, 64'd1_000_000_000, 63'd1, 64'd1, 63'd1, 0);
        send(OP_ADD, 64'd999_999_999, 63'd1, 64'd1, 63'd1, 0);
        send(OP_MUL, 64'd1, 63'd1_000_000_000, 64'd1, 63'd2, 0);
        send(OP_SUB, -64'd1, 63'd3, -64'd1, 63'd3, 0);
        drain();

        // Long receiver hold while requests keep coming.
        long_hold = 1'b1;
        wait (hold_active);
        long_hold = 1'b0;
        for (int i = 0; i < 6; i++)
            send(2'($urandom_range(0, 3)), pick_num(), pick_den(), pick_num(), pick_den(), 0);
        drain();

        // Random phases over several cap settings, extremes among them.
        caps[0] = 63'd0;
        caps[1] = 63'd1;
        caps[2] = 63'd1000;
        caps[3] = DEN_MAX;
        caps[4] = 63'({$urandom(), $urandom()});
        for (int p = 0; p < 5; p++) begin
            write_cap(caps[p]);
            random_phase(300);
        end

        drain();
        repeat (50) @(posedge aclk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("rational_alu_reduce_cap_tb: done, clean");
        else
            $display("rational_alu_reduce_cap_tb: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rarc_pkg.sv
rtl/core/rational_alu_reduce_cap.sv
dv/rational_alu_reduce_cap_tb.sv
